/* hw/rtl/congestion_window_sender_unit_defines.svh */
// Assertion macros for the congestion window sender unit.
// Included by files that carry concurrent checks; needs no package.
`ifndef CONGESTION_WINDOW_SENDER_UNIT_DEFINES_SVH
`define CONGESTION_WINDOW_SENDER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define CWS_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define CWS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CWS_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define CWS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

/* hw/rtl/cws_pkg.sv */
// Shared types, codes and constants of the congestion window sender unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package cws_pkg;

  localparam int SeqW     = 16;
  localparam int WideW    = 32;
  localparam int SegW     = 11;
  localparam int IseqW    = 13;
  localparam int ModW     = SeqW + 1;      // max_sequence + 1 needs one more bit
  localparam int SqW      = 2 * SegW;      // segment_size squared
  localparam int GrowW    = SqW + 1;
  localparam int ActW     = 2;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;
  localparam int DivW     = 32;            // dividend width of the serial divider
  localparam int DivCntW  = $clog2(DivW);

  // event codes
  localparam logic [ActW-1:0] ACT_SEND    = 2'd0;
  localparam logic [ActW-1:0] ACT_ACK     = 2'd1;
  localparam logic [ActW-1:0] ACT_TIMEOUT = 2'd2;

  // register indexes
  localparam logic [CfgIdxW-1:0] CFG_SEGMENT_SIZE      = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_MIN_WINDOW        = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_INITIAL_THRESHOLD = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_MAX_WINDOW        = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_MAX_SEQUENCE      = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_TRANSFER_LENGTH   = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_INITIAL_SEQUENCE  = 3'd6;

  // reset values
  localparam logic [SegW-1:0]  RST_SEGMENT_SIZE      = 11'd512;
  localparam logic [SeqW-1:0]  RST_MIN_WINDOW        = 16'd512;
  localparam logic [SeqW-1:0]  RST_INITIAL_THRESHOLD = 16'd10240;
  localparam logic [SeqW-1:0]  RST_MAX_WINDOW        = 16'd15360;
  localparam logic [SeqW-1:0]  RST_MAX_SEQUENCE      = 16'd25600;
  localparam logic [WideW-1:0] RST_TRANSFER_LENGTH   = 32'd0;
  localparam logic [IseqW-1:0] RST_INITIAL_SEQUENCE  = 13'd0;

  localparam logic [SeqW-1:0] THRESH_FLOOR = 16'd1024;

  typedef struct packed {
    logic [ActW-1:0] action;
    logic [SeqW-1:0] ack_number;
  } event_item_t;

  typedef struct packed {
    logic            segment_valid;
    logic [SeqW-1:0] segment_sequence;
    logic [SegW-1:0] segment_length;
    logic [SeqW-1:0] window_size;
    logic [SeqW-1:0] threshold_now;
    logic            in_slow_start;
    logic            transfer_done;
  } result_item_t;

  typedef struct packed {
    logic                en;
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_write_t;

  typedef struct packed {
    logic [SegW-1:0]  segment_size;
    logic [SeqW-1:0]  min_window;
    logic [SeqW-1:0]  initial_threshold;
    logic [SeqW-1:0]  max_window;
    logic [SeqW-1:0]  max_sequence;
    logic [WideW-1:0] transfer_length;
    logic [IseqW-1:0] initial_sequence;
  } cfg_t;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [ModW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quotient;
    logic [ModW-1:0] remainder;
  } div_rsp_t;

  typedef struct packed {
    logic         push;
    result_item_t item;
  } fin_t;

endpackage

/* hw/rtl/cws_cfg_regs.sv */
// Configuration register file of the congestion window sender unit.
// Depends on cws_pkg.
`timescale 1ns / 1ps

module cws_cfg_regs import cws_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_write_t cfg_wr,
  output cfg_t       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.segment_size      <= RST_SEGMENT_SIZE;
      cfg.min_window        <= RST_MIN_WINDOW;
      cfg.initial_threshold <= RST_INITIAL_THRESHOLD;
      cfg.max_window        <= RST_MAX_WINDOW;
      cfg.max_sequence      <= RST_MAX_SEQUENCE;
      cfg.transfer_length   <= RST_TRANSFER_LENGTH;
      cfg.initial_sequence  <= RST_INITIAL_SEQUENCE;
    end else if (cfg_wr.en) begin
      unique case (cfg_wr.index)
        CFG_SEGMENT_SIZE:      cfg.segment_size      <= cfg_wr.data[SegW-1:0];
        CFG_MIN_WINDOW:        cfg.min_window        <= cfg_wr.data[SeqW-1:0];
        CFG_INITIAL_THRESHOLD: cfg.initial_threshold <= cfg_wr.data[SeqW-1:0];
        CFG_MAX_WINDOW:        cfg.max_window        <= cfg_wr.data[SeqW-1:0];
        CFG_MAX_SEQUENCE:      cfg.max_sequence      <= cfg_wr.data[SeqW-1:0];
        CFG_TRANSFER_LENGTH:   cfg.transfer_length   <= cfg_wr.data[WideW-1:0];
        CFG_INITIAL_SEQUENCE:  cfg.initial_sequence  <= cfg_wr.data[IseqW-1:0];
        default: ;  // unused index, dropped
      endcase
    end
  end

endmodule

/* hw/rtl/cws_serial_div.sv */
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on cws_pkg.
`timescale 1ns / 1ps

module cws_serial_div import cws_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic               busy;
  logic               done;
  logic [DivCntW-1:0] cnt;
  logic [DivW-1:0]    quo;   // dividend shifts out at the top, quotient in at the bottom
  logic [ModW-1:0]    rem;
  logic [ModW-1:0]    dsr;
  logic [ModW:0]      trial;
  logic [ModW:0]      diff;
  logic               take;

  assign trial = {rem, quo[DivW-1]};
  assign diff  = trial - {1'b0, dsr};
  assign take  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dsr <= req.divisor;
      cnt <= DivCntW'(DivW - 1);
    end else if (busy) begin
      quo <= {quo[DivW-2:0], take};
      rem <= take ? diff[ModW-1:0] : trial[ModW-1:0];
      cnt <= cnt - 1'b1;
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

/* hw/rtl/cws_event_ctrl.sv */
// Event sequencer: window, threshold, sequence and base state plus the per-event flow.
// Depends on cws_pkg; drives the serial divider through div_req_t / div_rsp_t.
`timescale 1ns / 1ps

module cws_event_ctrl import cws_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        event_valid,
  output logic        event_stall,
  input  event_item_t event_item,
  input  cfg_t        cfg,
  input  cfg_write_t  cfg_wr,
  output div_req_t    div_req,
  input  div_rsp_t    div_rsp,
  input  logic        out_free,
  output fin_t        fin
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_PREP = 5'b00010,
    ST_EVAL = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

  state_t state, state_next;

  // architectural state
  logic             avoid;
  logic [SeqW-1:0]  cw;
  logic [SeqW-1:0]  ssth;
  logic [SeqW-1:0]  ns;
  logic [WideW-1:0] wo;
  logic [WideW-1:0] wb;

  // per-transaction work registers
  logic [ActW-1:0]  act;
  logic [SeqW-1:0]  ack;
  logic [WideW-1:0] sent_r;
  logic [WideW:0]   abs_next_r;
  logic [WideW:0]   abs_lim_r;
  logic [WideW-1:0] acked_r;
  logic [SqW-1:0]   sq_r;
  logic             seg_valid_r;
  logic [SeqW-1:0]  seq_r;
  logic [SegW-1:0]  len_r;
  logic [ModW-1:0]  s_r;
  logic             neg_r;

  logic [ModW-1:0]  modulus;
  logic [WideW-1:0] remain_base;
  logic [WideW-1:0] remain;
  logic [SegW-1:0]  len_pick;
  logic             has_room;
  logic             send_ok;
  logic             rto_ok;
  logic [WideW-1:0] wb_ack;
  logic [SeqW-1:0]  half;
  logic [SeqW-1:0]  ssth_rto;
  logic             wb_ge_wo;
  logic [WideW-1:0] rto_diff;
  logic [ModW-1:0]  s_send;
  logic [SqW-1:0]   grow_inc;
  logic [GrowW-1:0] grow_sum;
  logic [SeqW-1:0]  cw_grown;
  logic             need_div;
  logic [ModW-1:0]  mod_minus;
  logic [SeqW-1:0]  rto_seq;
  logic [WideW-1:0] wo_wrap;
  logic [WideW-1:0] sent_now;
  logic [WideW:0]   abs_now;
  logic             done_now;

  assign modulus     = {1'b0, cfg.max_sequence} + ModW'(1);
  assign event_stall = (state != ST_IDLE);

  // EVAL: window and length checks
  always_comb begin
    remain_base = (act == ACT_TIMEOUT) ? acked_r : sent_r;
    remain      = cfg.transfer_length - remain_base;
    len_pick    = (remain < WideW'(cfg.segment_size)) ? remain[SegW-1:0] : cfg.segment_size;
    has_room    = remain_base < cfg.transfer_length;
    send_ok     = has_room && (abs_next_r < abs_lim_r) && (len_pick != '0);
    rto_ok      = has_room && (len_pick != '0);
    s_send      = {1'b0, ns} + ModW'(len_pick);
    wb_ack      = (ack > ns) ? wo + WideW'(ack) - WideW'(modulus) : wo + WideW'(ack);
    half        = cw >> 1;
    ssth_rto    = (half > THRESH_FLOOR) ? half : THRESH_FLOOR;
    wb_ge_wo    = wb >= wo;
    rto_diff    = wb_ge_wo ? wb - wo : wo - wb;
  end

  // one adder for all window growth: slow start step, zero-window square, divider quotient
  always_comb begin
    if (state == ST_DIV)
      grow_inc = div_rsp.quotient[SqW-1:0];
    else if (avoid)
      grow_inc = sq_r;
    else
      grow_inc = SqW'(cfg.segment_size);
    grow_sum = GrowW'(cw) + GrowW'(grow_inc);
    cw_grown = (grow_sum < GrowW'(cfg.max_window)) ? grow_sum[SeqW-1:0] : cfg.max_window;
  end

  always_comb begin
    case (act)
      ACT_SEND:    need_div = send_ok;
      ACT_ACK:     need_div = avoid && (cw != '0);
      ACT_TIMEOUT: need_div = rto_ok;
      default:     need_div = 1'b0;
    endcase
    div_req.start    = (state == ST_EVAL) && need_div;
    div_req.dividend = (act == ACT_SEND) ? DivW'(s_send) :
                       (act == ACT_ACK)  ? DivW'(sq_r)   : rto_diff;
    div_req.divisor  = (act == ACT_ACK) ? ModW'(cw) : modulus;
  end

  // DIV completion
  always_comb begin
    mod_minus = modulus - div_rsp.remainder;
    if (!neg_r)
      rto_seq = div_rsp.remainder[SeqW-1:0];
    else if (div_rsp.remainder != '0)
      rto_seq = mod_minus[SeqW-1:0];
    else
      rto_seq = '0;
    wo_wrap = wo + WideW'(s_r - div_rsp.remainder);
  end

  // FIN: completion flag on the updated state
  always_comb begin
    sent_now = wo + WideW'(ns) - WideW'(cfg.initial_sequence);
    abs_now  = (WideW+1)'(wo) + (WideW+1)'(ns);
    done_now = (sent_now >= cfg.transfer_length) && ((WideW+1)'(wb) >= abs_now);
    fin.push                  = (state == ST_FIN) && out_free;
    fin.item.segment_valid    = seg_valid_r;
    fin.item.segment_sequence = seg_valid_r ? seq_r : '0;
    fin.item.segment_length   = seg_valid_r ? len_r : '0;
    fin.item.window_size      = cw;
    fin.item.threshold_now    = ssth;
    fin.item.in_slow_start    = !avoid;
    fin.item.transfer_done    = done_now;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (event_valid) state_next = ST_PREP;
      ST_PREP: state_next = ST_EVAL;
      ST_EVAL: state_next = need_div ? ST_DIV : ST_FIN;
      ST_DIV:  if (div_rsp.done) state_next = ST_FIN;
      ST_FIN:  if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      avoid <= 1'b0;
      cw    <= RST_MIN_WINDOW;
      ssth  <= RST_INITIAL_THRESHOLD;
      ns    <= SeqW'(RST_INITIAL_SEQUENCE);
      wo    <= '0;
      wb    <= WideW'(RST_INITIAL_SEQUENCE);
    end else begin
      state <= state_next;
      unique case (state)
        ST_EVAL: begin
          case (act)
            ACT_ACK: begin
              wb <= wb_ack;
              if (!avoid) begin
                if (cw < ssth) cw <= cw_grown;
                else avoid <= 1'b1;
              end else if (cw == '0) begin
                cw <= cw_grown;  // zero window: step is the full square
              end
            end
            ACT_TIMEOUT: begin
              ssth  <= ssth_rto;
              cw    <= cfg.min_window;
              avoid <= 1'b0;
            end
            default: ;
          endcase
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            case (act)
              ACT_SEND: begin
                wo <= wo_wrap;
                ns <= div_rsp.remainder[SeqW-1:0];
              end
              ACT_ACK: cw <= cw_grown;
              default: ;
            endcase
          end
        end
        default: ;
      endcase
      if (cfg_wr.en) begin
        unique case (cfg_wr.index)
          CFG_MIN_WINDOW:        cw   <= cfg_wr.data[SeqW-1:0];
          CFG_INITIAL_THRESHOLD: ssth <= cfg_wr.data[SeqW-1:0];
          CFG_INITIAL_SEQUENCE: begin
            ns <= SeqW'(cfg_wr.data[IseqW-1:0]);
            wb <= WideW'(cfg_wr.data[IseqW-1:0]);
            wo <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (event_valid) begin
          act <= event_item.action;
          ack <= event_item.ack_number;
        end
      end
      ST_PREP: begin
        sent_r     <= wo + WideW'(ns) - WideW'(cfg.initial_sequence);
        abs_next_r <= (WideW+1)'(wo) + (WideW+1)'(ns);
        abs_lim_r  <= (WideW+1)'(wb) + (WideW+1)'(cw);
        acked_r    <= wb - WideW'(cfg.initial_sequence);
        sq_r       <= SqW'(cfg.segment_size) * SqW'(cfg.segment_size);
      end
      ST_EVAL: begin
        seg_valid_r <= ((act == ACT_SEND) && send_ok) || ((act == ACT_TIMEOUT) && rto_ok);
        seq_r       <= ns;
        len_r       <= len_pick;
        s_r         <= s_send;
        neg_r       <= !wb_ge_wo;
      end
      ST_DIV: begin
        if (div_rsp.done && act == ACT_TIMEOUT) seq_r <= rto_seq;
      end
      default: ;
    endcase
  end

endmodule

/* hw/rtl/congestion_window_sender_unit.sv */
// Congestion window sender unit (slow start / avoidance / timeout): top level.
// Event channel in, result channel out (valid/stall), plain config write port.
// Steps: an event taken in IDLE passes PREP and EVAL, then DIV when a division is
//   needed (not for no segment, slow-start or zero-window ack, ignored code),
//   then FIN, which loads the output register once it is free; the 32-step
//   bit-serial divider (sequence wrap, retransmit sequence, avoidance growth) makes the slow path.
// The next event is taken while a finished result still waits in the output
//   register; the sequencer only holds in its last step if that register is
//   still full and stalled, and event_stall stays high until it drains.
// A stalled result holds its payload; nothing is dropped or repeated.
// Reset (rst, synchronous): registers back to their defaults, window and
//   threshold reloaded, sequence and base at the initial sequence, no result.
// Config writes take effect at once; issue them only while the unit is idle.
// Depends on cws_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "congestion_window_sender_unit_defines.svh"

module congestion_window_sender_unit import cws_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  // event channel
  input  logic                event_valid,
  output logic                event_stall,
  input  event_item_t         event_item,
  // result channel
  output logic                result_valid,
  input  logic                result_stall,
  output result_item_t        result_item,
  // configuration writes
  input  logic                cfg_wr_en,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  cfg_write_t cfg_wr;
  cfg_t       cfg;
  div_req_t   div_req;
  div_rsp_t   div_rsp;
  fin_t       fin;
  logic       out_free;

  assign cfg_wr.en    = cfg_wr_en;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  cws_cfg_regs u_cfg (
    .clk    (clk),
    .rst    (rst),
    .cfg_wr (cfg_wr),
    .cfg    (cfg)
  );

  // shared by sequence wrap, retransmit sequence and avoidance growth
  cws_serial_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  cws_event_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .event_valid (event_valid),
    .event_stall (event_stall),
    .event_item  (event_item),
    .cfg         (cfg),
    .cfg_wr      (cfg_wr),
    .div_req     (div_req),
    .div_rsp     (div_rsp),
    .out_free    (out_free),
    .fin         (fin)
  );

  // Output register: free when empty or being taken this cycle.
  assign out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fin.push) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin.push) result_item <= fin.item;
  end

  // sequencer never overwrites a result that is still waiting
  `CWS_ASSERT_IMPLIES(a_push_into_free, clk, rst, fin.push, !result_valid || !result_stall, "result overwritten while stalled")
  // one event at a time: a transaction closes the event channel next cycle
  `CWS_ASSERT_NEXT(a_one_in_flight, clk, rst, event_valid && !event_stall, event_stall, "second event taken while busy")
  // no segment means zeroed segment fields
  `CWS_ASSERT_IMPLIES(a_empty_segment, clk, rst, result_valid && !result_item.segment_valid, result_item.segment_length == '0 && result_item.segment_sequence == '0, "segment fields set without a segment")

endmodule

/* tb/congestion_window_sender_unit_checker.sv */
// Checker for the congestion window sender unit: mirrors the register file and
// window state, predicts one report per event transaction and compares it.
// Depends on cws_pkg for the transaction structs, event codes and reset values.
`timescale 1ns / 1ps

module congestion_window_sender_unit_checker import cws_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                event_valid,
  input  logic                event_stall,
  input  event_item_t         event_item,
  input  logic                result_valid,
  input  logic                result_stall,
  input  result_item_t        result_item,
  input  logic                cfg_wr_en,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  output int                  mismatch_count,
  output int                  reports_pending
);

  // mirrored registers
  logic [SegW-1:0]  mss;
  logic [SeqW-1:0]  floor_window;
  logic [SeqW-1:0]  ssthresh_init;
  logic [SeqW-1:0]  cap_window;
  logic [SeqW-1:0]  seq_max;
  logic [WideW-1:0] xfer_len;
  logic [IseqW-1:0] seq_start;

  // mirrored window state
  logic             avoid_q;
  logic [SeqW-1:0]  cwnd_q;
  logic [SeqW-1:0]  ssthresh_q;
  logic [SeqW-1:0]  seq_next_q;
  logic [WideW-1:0] wrap_acc_q;
  logic [WideW-1:0] base_q;

  result_item_t pending_reports[$];

  function automatic logic [WideW-1:0] min_bytes(logic [WideW-1:0] a, logic [WideW-1:0] b);
    return (a < b) ? a : b;
  endfunction

  // window growth, held at the cap
  function automatic logic [SeqW-1:0] capped(logic [WideW-1:0] grown);
    return (grown < WideW'(cap_window)) ? grown[SeqW-1:0] : cap_window;
  endfunction

  function automatic void apply_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    case (idx)
      CFG_SEGMENT_SIZE:      mss = val[SegW-1:0];
      CFG_MIN_WINDOW: begin
        floor_window = val[SeqW-1:0];
        cwnd_q       = val[SeqW-1:0];
      end
      CFG_INITIAL_THRESHOLD: begin
        ssthresh_init = val[SeqW-1:0];
        ssthresh_q    = val[SeqW-1:0];
      end
      CFG_MAX_WINDOW:        cap_window = val[SeqW-1:0];
      CFG_MAX_SEQUENCE:      seq_max = val[SeqW-1:0];
      CFG_TRANSFER_LENGTH:   xfer_len = val[WideW-1:0];
      CFG_INITIAL_SEQUENCE: begin
        seq_start  = val[IseqW-1:0];
        seq_next_q = SeqW'(val[IseqW-1:0]);
        base_q     = WideW'(val[IseqW-1:0]);
        wrap_acc_q = '0;
      end
      default: ;
    endcase
  endfunction

  // Advances the window state by one event and returns the report it causes.
  function automatic result_item_t advance_window_state(event_item_t ev);
    logic [WideW-1:0] modulus, sent, len, s, seq, acked, half, sq, inc, r;
    logic             hit;
    result_item_t     rep;
    hit     = 1'b0;
    seq     = '0;
    len     = '0;
    modulus = WideW'(seq_max) + 32'd1;
    case (ev.action)
      ACT_SEND: begin
        sent = wrap_acc_q + WideW'(seq_next_q) - WideW'(seq_start);
        if (sent < xfer_len &&
            64'(wrap_acc_q) + 64'(seq_next_q) < 64'(base_q) + 64'(cwnd_q)) begin
          len = min_bytes(WideW'(mss), xfer_len - sent);
          if (len != 0) begin
            hit = 1'b1;
            seq = WideW'(seq_next_q);
            s   = WideW'(seq_next_q) + len;
            if (s > WideW'(seq_max)) begin
              wrap_acc_q = wrap_acc_q + (s / modulus) * modulus;
              s          = s % modulus;
            end
            seq_next_q = s[SeqW-1:0];
          end
        end
      end
      ACT_ACK: begin
        // an ack beyond the next sequence belongs to the previous wrap
        if (ev.ack_number > seq_next_q)
          base_q = wrap_acc_q + WideW'(ev.ack_number) - modulus;
        else
          base_q = wrap_acc_q + WideW'(ev.ack_number);
        if (!avoid_q) begin
          if (cwnd_q < ssthresh_q)
            cwnd_q = capped(WideW'(cwnd_q) + WideW'(mss));
          else
            avoid_q = 1'b1;
        end else begin
          sq     = WideW'(mss) * WideW'(mss);
          inc    = (cwnd_q != 0) ? sq / WideW'(cwnd_q) : sq;
          cwnd_q = capped(WideW'(cwnd_q) + inc);
        end
      end
      ACT_TIMEOUT: begin
        half       = WideW'(cwnd_q >> 1);
        acked      = base_q - WideW'(seq_start);
        ssthresh_q = (half > WideW'(THRESH_FLOOR)) ? half[SeqW-1:0] : THRESH_FLOOR;
        cwnd_q     = floor_window;
        avoid_q    = 1'b0;
        if (acked < xfer_len) begin
          len = min_bytes(WideW'(mss), xfer_len - acked);
          if (len != 0) begin
            hit = 1'b1;
            if (base_q >= wrap_acc_q) begin
              seq = (base_q - wrap_acc_q) % modulus;
            end else begin
              r   = (wrap_acc_q - base_q) % modulus;
              seq = (r != 0) ? modulus - r : '0;
            end
          end
        end
      end
      default: ;
    endcase
    if (!hit) begin
      seq = '0;
      len = '0;
    end
    rep.segment_valid    = hit;
    rep.segment_sequence = seq[SeqW-1:0];
    rep.segment_length   = len[SegW-1:0];
    rep.window_size      = cwnd_q;
    rep.threshold_now    = ssthresh_q;
    rep.in_slow_start    = !avoid_q;
    rep.transfer_done    = (wrap_acc_q + WideW'(seq_next_q) - WideW'(seq_start) >= xfer_len) &&
                           (64'(base_q) >= 64'(wrap_acc_q) + 64'(seq_next_q));
    return rep;
  endfunction

  task automatic check_field(input string label, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: %s expected %0d got %0d", $time, label, want, got);
    end
  endtask

  always @(posedge clk) begin
    result_item_t want;
    if (rst) begin
      mss           = RST_SEGMENT_SIZE;
      floor_window  = RST_MIN_WINDOW;
      ssthresh_init = RST_INITIAL_THRESHOLD;
      cap_window    = RST_MAX_WINDOW;
      seq_max       = RST_MAX_SEQUENCE;
      xfer_len      = RST_TRANSFER_LENGTH;
      seq_start     = RST_INITIAL_SEQUENCE;
      avoid_q       = 1'b0;
      cwnd_q        = RST_MIN_WINDOW;
      ssthresh_q    = RST_INITIAL_THRESHOLD;
      seq_next_q    = SeqW'(RST_INITIAL_SEQUENCE);
      wrap_acc_q    = '0;
      base_q        = WideW'(RST_INITIAL_SEQUENCE);
      pending_reports.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_wr_en)
        apply_register(cfg_index, cfg_data);
      if (event_valid && !event_stall)
        pending_reports.push_back(advance_window_state(event_item));
      if (result_valid && !result_stall) begin
        if (pending_reports.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: result transaction with no event waiting", $time);
        end else begin
          want = pending_reports.pop_front();
          check_field("segment_valid", want.segment_valid, result_item.segment_valid);
          check_field("segment_sequence", want.segment_sequence,
                      result_item.segment_sequence);
          check_field("segment_length", want.segment_length, result_item.segment_length);
          check_field("window_size", want.window_size, result_item.window_size);
          check_field("threshold_now", want.threshold_now, result_item.threshold_now);
          check_field("in_slow_start", want.in_slow_start, result_item.in_slow_start);
          check_field("transfer_done", want.transfer_done, result_item.transfer_done);
        end
      end
    end
    reports_pending <= pending_reports.size();
  end

endmodule

/* tb/congestion_window_sender_unit_tb.sv */
// Top of the congestion window sender unit testbench: clock, reset, register
// programming, event stimulus and result back-pressure, and the final verdict.
// Depends on cws_pkg, the unit itself and congestion_window_sender_unit_checker.
`timescale 1ns / 1ps

module congestion_window_sender_unit_tb import cws_pkg::*;;

  // event code and register index the package leaves unnamed
  localparam logic [ActW-1:0]    ACT_IGNORED      = 2'd3;
  localparam logic [CfgIdxW-1:0] CFG_UNUSED_INDEX = 3'd7;
  // covers the slow path of the unit with some margin
  localparam int DRAIN_CYCLES = 40;

  logic                clk = 1'b0;
  logic                rst;
  logic                event_valid;
  logic                event_stall;
  event_item_t         event_item;
  logic                result_valid;
  logic                result_stall;
  result_item_t        result_item;
  logic                cfg_wr_en;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  int mismatch_count;
  int reports_pending;

  // Stimulus-side bookkeeping: where recent segments end, so that acks can
  // acknowledge real data instead of random numbers.
  logic [SeqW-1:0] seg_ends[$];
  logic [SeqW-1:0] cur_seq_max;

  // Stretches with no idling on either side.
  logic send_quiet;
  logic recv_quiet;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  congestion_window_sender_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .event_valid  (event_valid),
    .event_stall  (event_stall),
    .event_item   (event_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  congestion_window_sender_unit_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .event_valid     (event_valid),
    .event_stall     (event_stall),
    .event_item      (event_item),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .result_item     (result_item),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .reports_pending (reports_pending)
  );

  // Remember where each emitted or retransmitted segment ends (mod seq space).
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall && result_item.segment_valid) begin
      seg_ends.push_back(SeqW'((32'(result_item.segment_sequence) +
                                32'(result_item.segment_length)) %
                               (32'(cur_seq_max) + 32'd1)));
      if (seg_ends.size() > 8)
        void'(seg_ends.pop_front());
    end
  end

  // Result side: after each result transaction draw a random stall, none in
  // quiet stretches. The stall lands wherever the unit happens to be in its next
  // event; the sequencer only feels it in FIN, with the output register still full.
  initial begin
    int hold;
    hold = 0;
    result_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (result_valid && !result_stall)
        hold = recv_quiet ? 0 : $urandom_range(0, 6);
      @(negedge clk);
      result_stall <= (hold > 0);
      if (hold > 0)
        hold--;
    end
  end

  // One event transaction: a random idle gap (none in quiet stretches), then hold
  // valid and the payload steady until the unit takes it. Valid stays high on
  // return so back-to-back transactions never drop it within one time step.
  task automatic issue_event(input logic [ActW-1:0] act, input logic [SeqW-1:0] ack);
    int gap;
    gap = send_quiet ? 0 : $urandom_range(0, 6);
    @(negedge clk);
    if (gap > 0) begin
      event_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    event_valid <= 1'b1;
    event_item  <= '{action: act, ack_number: ack};
    do @(posedge clk); while (event_stall);
  endtask

  // Stop sending and wait until every predicted report has come back.
  task automatic drain_reports();
    @(negedge clk);
    event_valid <= 1'b0;
    while (reports_pending != 0) @(negedge clk);
  endtask

  // Full idle: reports drained, then enough cycles for any slow step to end.
  task automatic settle();
    drain_reports();
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Register write; about half the writes narrower than 32 bits carry junk above the width.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val,
                           input int width);
    logic [31:0] data;
    data = val;
    if (width < 32 && $urandom_range(0, 1) == 1)
      data = data | ($urandom << width);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
  endtask

  task automatic load_settings(input logic [31:0] seg, input logic [31:0] minw,
                               input logic [31:0] ith, input logic [31:0] maxw,
                               input logic [31:0] maxseq, input logic [31:0] tlen,
                               input logic [31:0] iseq);
    write_reg(CFG_SEGMENT_SIZE, seg, SegW);
    write_reg(CFG_MIN_WINDOW, minw, SeqW);
    write_reg(CFG_INITIAL_THRESHOLD, ith, SeqW);
    write_reg(CFG_MAX_WINDOW, maxw, SeqW);
    write_reg(CFG_MAX_SEQUENCE, maxseq, SeqW);
    write_reg(CFG_TRANSFER_LENGTH, tlen, WideW);
    write_reg(CFG_INITIAL_SEQUENCE, iseq, IseqW);
    // an out-of-map index must leave everything alone
    write_reg(CFG_UNUSED_INDEX, $urandom, CfgDataW);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cur_seq_max = maxseq[SeqW-1:0];
    seg_ends.delete();
  endtask

  // Mostly the end of the newest segment (cumulative ack of everything sent),
  // sometimes an older end, now and then an arbitrary number.
  function automatic logic [SeqW-1:0] pick_ack();
    if (seg_ends.size() == 0 || $urandom_range(0, 99) < 12)
      return SeqW'($urandom);
    if ($urandom_range(0, 99) < 70)
      return seg_ends[$];
    return seg_ends[$urandom_range(0, seg_ends.size() - 1)];
  endfunction

  // Random traffic: a send/ack dialogue with occasional timeouts, unused
  // codes and pure noise. Midway the sender holds off until all reports are in.
  task automatic run_traffic(input int n);
    int pick;
    for (int i = 0; i < n; i++) begin
      if (i % 50 == 0) begin
        send_quiet = ($urandom_range(0, 3) == 0);
        recv_quiet = ($urandom_range(0, 3) == 0);
      end
      if (i == n / 2)
        drain_reports();
      pick = $urandom_range(0, 99);
      if (pick < 48)
        issue_event(ACT_SEND, SeqW'($urandom));
      else if (pick < 88)
        issue_event(ACT_ACK, pick_ack());
      else if (pick < 94)
        issue_event(ACT_TIMEOUT, SeqW'($urandom));
      else if (pick < 97)
        issue_event(ACT_IGNORED, SeqW'($urandom));
      else
        issue_event(ActW'($urandom_range(0, 3)), SeqW'($urandom));
    end
  endtask

  initial begin
    rst         = 1'b1;
    event_valid = 1'b0;
    event_item  = '0;
    cfg_wr_en   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    send_quiet  = 1'b0;
    recv_quiet  = 1'b0;
    cur_seq_max = RST_MAX_SEQUENCE;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset defaults, nothing to send: every code, an ack from the previous
    // wrap (above next sequence), an ignored code with a busy ack field.
    issue_event(ACT_SEND, 16'h0000);
    issue_event(ACT_ACK, 16'h0000);
    issue_event(ACT_ACK, 16'hFFFF);
    issue_event(ACT_TIMEOUT, 16'h0000);
    issue_event(ACT_IGNORED, 16'hAAAA);
    issue_event(ACT_ACK, 16'h5555);

    // Largest segments, small sequence space so the first sends wrap, window
    // fills after two segments, first ack at threshold switches to avoidance,
    // last segment is short, then a retransmit and an ack past next sequence.
    settle();
    load_settings(1024, 2048, 2048, 65535, 4095, 5000, 4000);
    repeat (3) issue_event(ACT_SEND, 16'h0000);
    issue_event(ACT_ACK, 16'd928);
    issue_event(ACT_ACK, 16'd1952);
    repeat (4) issue_event(ACT_SEND, 16'h0000);
    issue_event(ACT_TIMEOUT, 16'h0000);
    issue_event(ACT_ACK, 16'd4000);
    issue_event(ACT_SEND, 16'h0000);

    // Zero window straight into avoidance: growth is the squared segment size.
    settle();
    load_settings(3, 0, 0, 65535, 65535, 100, 0);
    issue_event(ACT_ACK, 16'h0000);
    issue_event(ACT_ACK, 16'h0000);
    issue_event(ACT_SEND, 16'h0000);

    // Random phases, each under its own register settings.
    for (int p = 0; p < 8; p++) begin
      settle();
      case (p)
        0: load_settings(512, 512, 10240, 15360, 25600, 60000, 0);
        1: load_settings(1, 1, 1, 1, 1, 300, 0);
        2: load_settings(1024, 65535, 65535, 65535, 65535, 32'hFFFF_FFFF, 4999);
        3: load_settings(0, 1024, 4096, 20000, 30000, 5000, 17);   // zero-length segments
        4: load_settings(100, 300, 2000, 8000, 999, 20000, 123);
        7: load_settings(1024, 4096, 1024, 65535, 5000, 32'h0010_0000, 4999);
        default:
          load_settings($urandom_range(1, 1024), $urandom_range(1, 65535),
                        $urandom_range(1, 65535), $urandom_range(1, 65535),
                        $urandom_range(500, 8000), $urandom_range(0, 300000),
                        $urandom_range(0, 4999));
      endcase
      run_traffic((p == 3) ? 60 : 230);
    end

    settle();
    if (mismatch_count == 0)
      $display("congestion_window_sender_unit_tb: PASS");
    else
      $display("congestion_window_sender_unit_tb: FAIL");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("congestion_window_sender_unit_tb: FAIL");
    $finish;
  end

endmodule
